>>> rtl/ppl_pkg.sv
// Shared constants and types of the plateau peak labeler.
`default_nettype none
package ppl_pkg;

  localparam int RUN_MAX    = 64;
  localparam int INDEX_BITS = 16;

  localparam int XW         = 32;
  localparam int YW         = 32;
  localparam int OUT_IDX_W  = 16;
  localparam int ADDR_W     = $clog2(RUN_MAX);
  localparam int LEN_W      = $clog2(RUN_MAX + 2);
  localparam int SUM_W      = (INDEX_BITS > OUT_IDX_W) ? INDEX_BITS : OUT_IDX_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FIND_MAX  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;

  // Labeled extremum leaving the run tracker; x comes from the store's registered read port in the next cycle.
  typedef struct packed {
    logic                 valid;
    logic [OUT_IDX_W-1:0] index;
  } peak_req_t;

endpackage
`default_nettype wire

>>> rtl/ppl_point_if.sv
// Input channel: one spectrum point per beat.
`default_nettype none
interface ppl_point_if;
  logic               valid;
  logic               ready;
  logic               first_point;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;

  modport source (output valid, first_point, x_value, y_value, input ready);
  modport sink (input valid, first_point, x_value, y_value, output ready);
endinterface
`default_nettype wire

>>> rtl/ppl_peak_if.sv
// Output channel: one labeled extremum per beat.
`default_nettype none
interface ppl_peak_if;
  logic               valid;
  logic               ready;
  logic [15:0]        peak_index;
  logic signed [31:0] peak_x;

  modport source (output valid, peak_index, peak_x, input ready);
  modport sink (input valid, peak_index, peak_x, output ready);
endinterface
`default_nettype wire

>>> rtl/ppl_ram.sv
// Generic single-clock RAM, one write and one registered read port, read-first.
`default_nettype none
module ppl_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/ppl_track.sv
// Run tracker: judges plateaus and drives the x store.
`default_nettype none
module ppl_track (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  ppl_point_if.sink                        point_i,
  input  wire logic                        s1_free_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [ppl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ppl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                             ram_we_o,
  output logic      [ppl_pkg::ADDR_W-1:0]  ram_waddr_o,
  output logic      [ppl_pkg::XW-1:0]      ram_wdata_o,
  output logic                             ram_re_o,
  output logic      [ppl_pkg::ADDR_W-1:0]  ram_raddr_o,
  output ppl_pkg::peak_req_t               req_o
);
  import ppl_pkg::*;

  localparam logic [INDEX_BITS-1:0] IndexMax = {INDEX_BITS{1'b1}};
  localparam logic [LEN_W-1:0]      RunMax   = LEN_W'(RUN_MAX);
  localparam logic [LEN_W-1:0]      RunLong  = LEN_W'(RUN_MAX + 1);

  logic                    find_max_q;
  logic signed [YW-1:0]    threshold_q;
  logic [INDEX_BITS-1:0]   point_count_q, point_count_d;
  logic signed [YW-1:0]    left_level_q, left_level_d;
  logic                    left_valid_q, left_valid_d;
  logic signed [YW-1:0]    run_level_q, run_level_d;
  logic [INDEX_BITS-1:0]   run_start_q, run_start_d;
  logic [LEN_W-1:0]        run_len_q, run_len_d;

  logic                    accept;
  logic                    start;
  logic                    same;
  logic                    hit;
  logic signed [YW-1:0]    y;
  logic [LEN_W-1:0]        mid;
  logic [SUM_W-1:0]        idx_sum;

  assign point_i.ready = s1_free_i;
  assign accept = point_i.valid && point_i.ready;
  assign y      = point_i.y_value;
  assign start  = point_i.first_point || (run_len_q == '0);
  assign same   = (y == run_level_q);

  always_comb begin
    if (find_max_q) begin
      hit = (run_level_q > left_level_q) && (run_level_q > y) && (run_level_q >= threshold_q);
    end else begin
      hit = (run_level_q < left_level_q) && (run_level_q < y) && (run_level_q <= threshold_q);
    end
  end

  // Lower middle of the run.
  assign mid     = (run_len_q - LEN_W'(1)) >> 1;
  assign idx_sum = SUM_W'(run_start_q) + SUM_W'(mid);

  assign req_o.valid = accept && !start && !same && hit && left_valid_q && (run_len_q <= RunMax);
  assign req_o.index = idx_sum[OUT_IDX_W-1:0];

  assign ram_re_o    = req_o.valid;
  assign ram_raddr_o = mid[ADDR_W-1:0];

  // Extending a run appends x; a new run starts at entry zero.
  assign ram_we_o    = accept && (start || !same || (run_len_q < RunMax));
  assign ram_waddr_o = (start || !same) ? '0 : run_len_q[ADDR_W-1:0];
  assign ram_wdata_o = point_i.x_value;

  always_comb begin
    point_count_d = point_count_q;
    left_level_d  = left_level_q;
    left_valid_d  = left_valid_q;
    run_level_d   = run_level_q;
    run_start_d   = run_start_q;
    run_len_d     = run_len_q;
    if (accept) begin
      if (start) begin
        left_valid_d  = 1'b0;
        left_level_d  = '0;
        run_level_d   = y;
        run_start_d   = '0;
        run_len_d     = LEN_W'(1);
        point_count_d = INDEX_BITS'(1);
      end else begin
        if (same) begin
          run_len_d = (run_len_q < RunMax) ? run_len_q + LEN_W'(1) : RunLong;
        end else begin
          left_level_d = run_level_q;
          left_valid_d = 1'b1;
          run_level_d  = y;
          run_start_d  = point_count_q;
          run_len_d    = LEN_W'(1);
        end
        if (point_count_q != IndexMax) begin
          point_count_d = point_count_q + INDEX_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      find_max_q    <= 1'b1;
      threshold_q   <= '0;
      point_count_q <= '0;
      left_level_q  <= '0;
      left_valid_q  <= 1'b0;
      run_level_q   <= '0;
      run_start_q   <= '0;
      run_len_q     <= '0;
    end else begin
      point_count_q <= point_count_d;
      left_level_q  <= left_level_d;
      left_valid_q  <= left_valid_d;
      run_level_q   <= run_level_d;
      run_start_q   <= run_start_d;
      run_len_q     <= run_len_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FIND_MAX:  find_max_q  <= cfg_data_i[0];
          REG_THRESHOLD: threshold_q <= cfg_data_i[YW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/ppl_out.sv
// Result stage: pairs the index with the store's read data, then an output register.
`default_nettype none
module ppl_out (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  ppl_pkg::peak_req_t          req_i,
  input  wire logic [ppl_pkg::XW-1:0] rd_data_i,
  output logic                        s1_free_o,
  output logic                        s1_busy_o,
  ppl_peak_if.source                  peak_o
);
  import ppl_pkg::*;

  logic                 s1_valid_q, s1_valid_d;
  logic [OUT_IDX_W-1:0] s1_index_q;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_IDX_W-1:0] out_index_q;
  logic [XW-1:0]        out_x_q;
  logic                 s1_adv;

  assign s1_adv    = s1_valid_q && (!out_valid_q || peak_o.ready);
  assign s1_free_o = !s1_valid_q || s1_adv;
  assign s1_busy_o = s1_valid_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_free_o) begin
      s1_valid_d = req_i.valid;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (peak_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free_o && req_i.valid) begin
      s1_index_q <= req_i.index;
    end
    if (s1_adv) begin
      out_index_q <= s1_index_q;
      out_x_q     <= rd_data_i;
    end
  end

  assign peak_o.valid      = out_valid_q;
  assign peak_o.peak_index = out_index_q;
  assign peak_o.peak_x     = out_x_q;

endmodule
`default_nettype wire

>>> rtl/plateau_peak_labeler.sv
// Plateau peak labeler: labels strict local extrema of a point stream, plateaus included.
//
// point_i takes one (first_point, x_value, y_value) beat per cycle while ready is high; peak_o gives
// (peak_index, peak_x) for each labeled extremum, at most one per input beat.
// A plateau is judged on the beat that ends it; its lower-middle point is labeled.
// Throughput: one point per cycle unless the result stages are full; the single write and read port
// of the x store (RUN_MAX entries) is touched once per beat by the tracker.
// The edge that accepts the beat ending a plateau reads the store and loads the result stage;
// the output register then takes both once it is empty or peak_o is ready, and drives peak_o.
// When peak_o is stalled, the output register and the stage behind it each hold
// one result; point_i stays ready until both are full, then drops ready.
// Reset (rst_ni low, asynchronous) empties both stages, closes any open run and
// sets find_max to 1 and threshold to 0. The store needs no clearing pass.
// Write find_max (index 0) and threshold (index 1) through cfg_we_i only while idle.
`default_nettype none
module plateau_peak_labeler (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  ppl_point_if.sink                           point_i,
  ppl_peak_if.source                          peak_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [ppl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ppl_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ppl_pkg::*;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [XW-1:0]     ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [XW-1:0]     ram_rdata;
  peak_req_t         req;
  logic              s1_free;
  logic              s1_busy;

  ppl_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .point_i     (point_i),
    .s1_free_i   (s1_free),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .req_o       (req)
  );

  ppl_ram #(
    .Width (XW),
    .Depth (RUN_MAX)
  ) u_run_x_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ppl_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rd_data_i (ram_rdata),
    .s1_free_o (s1_free),
    .s1_busy_o (s1_busy),
    .peak_o    (peak_o)
  );

`ifndef ASSERT_OFF
  // A labeled beat must land in the result stage on the next edge.
  a_req_to_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid |=> s1_busy)
    else $error("labeled beat not captured by result stage");

  // Both stages full and stalled: no new point may enter.
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_busy && peak_o.valid && !peak_o.ready) |-> !point_i.ready)
    else $error("point accepted while result stages are full");

  // A store read happens only on an accepted point.
  a_read_on_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (point_i.valid && point_i.ready))
    else $error("store read without an accepted point");
`endif

endmodule
`default_nettype wire

>>> dv/tb_plateau_peak_labeler.sv
// Testbench for plateau_peak_labeler: directed and random point series against a peak predictor.
module tb_plateau_peak_labeler;
  timeunit 1ns;
  timeprecision 1ps;

  import ppl_pkg::*;

  localparam int     SETTLE_CYCLES = 6;
  localparam longint CYCLE_LIMIT   = 500000;
  localparam int     RANDOM_POINTS = 196;
  localparam int     RANDOM_PHASES = 7;
  localparam longint INDEX_CAP     = (64'sd1 << INDEX_BITS) - 1;
  localparam longint LEVEL_TOP     = 64'sh7FFF_FFFF;
  localparam longint LEVEL_BOTTOM  = -64'sh8000_0000;

  localparam logic signed [31:0] Y_TOP    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Y_BOTTOM = 32'sh8000_0000;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] index;
    logic signed [XW-1:0] x;
  } peak_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ppl_point_if point_bus ();
  ppl_peak_if  peak_bus ();

  plateau_peak_labeler dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .point_i    (point_bus),
    .peak_o     (peak_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor state, mirrors the block after reset.
  logic               find_max_q    = 1'b1;
  logic signed [31:0] thresh_q      = '0;
  longint             next_index    = 0;
  logic signed [31:0] left_level    = '0;
  bit                 left_known    = 1'b0;
  logic signed [31:0] plateau_level = '0;
  longint             plateau_start = 0;
  int                 plateau_len   = 0;
  logic signed [31:0] plateau_x [RUN_MAX];

  peak_t  peaks_due [$];
  int     err_count       = 0;
  int     points_sent     = 0;
  int     peaks_predicted = 0;
  int     peaks_seen      = 0;
  longint cycle_count     = 0;
  bit     no_gaps         = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d peaks outstanding", cycle_count, peaks_due.size());
      $display("plateau_peak_labeler test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 30) $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  function automatic void predict_point(input bit first, input logic signed [31:0] x,
                                        input logic signed [31:0] y);
    bit    hit;
    int    mid;
    peak_t pk;
    if (first || plateau_len == 0) begin
      next_index    = 0;
      left_known    = 1'b0;
      left_level    = '0;
      plateau_level = y;
      plateau_start = 0;
      plateau_len   = 1;
      plateau_x[0]  = x;
    end else if (y == plateau_level) begin
      if (plateau_len < RUN_MAX) begin
        plateau_x[plateau_len] = x;
        plateau_len++;
      end else begin
        plateau_len = RUN_MAX + 1;
      end
    end else begin
      if (find_max_q)
        hit = plateau_level > left_level && plateau_level > y && plateau_level >= thresh_q;
      else
        hit = plateau_level < left_level && plateau_level < y && plateau_level <= thresh_q;
      if (hit && left_known && plateau_len <= RUN_MAX) begin
        mid      = (plateau_len - 1) / 2;
        // index wraps when a saturated start plus the middle offset passes 16 bits
        pk.index = OUT_IDX_W'(plateau_start + mid);
        pk.x     = plateau_x[mid];
        peaks_due.push_back(pk);
        peaks_predicted++;
      end
      left_level    = plateau_level;
      left_known    = 1'b1;
      plateau_level = y;
      plateau_start = next_index;
      plateau_len   = 1;
      plateau_x[0]  = x;
    end
    if (next_index < INDEX_CAP) next_index++;
  endfunction

  task automatic send_point(input bit first, input logic signed [31:0] x,
                            input logic signed [31:0] y);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      point_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    point_bus.valid       <= 1'b1;
    point_bus.first_point <= first;
    point_bus.x_value     <= x;
    point_bus.y_value     <= y;
    do @(posedge clk_i); while (!point_bus.ready);
    predict_point(first, x, y);
    points_sent++;
  endtask

  // Hold the input idle until every predicted peak is out and the pipeline is empty.
  task automatic wait_idle();
    point_bus.valid <= 1'b0;
    while (peaks_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_FIND_MAX) find_max_q = data[0];
    else if (idx == REG_THRESHOLD) thresh_q = data;
  endtask

  task automatic configure(input bit fmax, input logic signed [31:0] thr);
    wait_idle();
    set_reg(REG_FIND_MAX, CFG_DATA_W'(fmax));
    set_reg(REG_THRESHOLD, thr);
  endtask

  // Runs with default registers; the very first beat does not flag a new series.
  task automatic test_unstarted_series();
    int ys[];
    ys = '{5, 5, 3, 7, 7, 2};
    foreach (ys[i]) send_point(1'b0, $urandom(), ys[i]);
  endtask

  task automatic test_max_search();
    int ys[];
    configure(1'b1, 32'sd0);
    ys = '{-1, 0, -1, 4, 4, -3, Y_TOP, -5, -9, -4, -9, 6, 8, 2, 5, 1};
    // restart at the 8 drops the open run at 6
    foreach (ys[i]) send_point(i == 0 || i == 12, $urandom(), ys[i]);
  endtask

  task automatic test_min_search();
    int ys[];
    configure(1'b0, 32'sd0);
    ys = '{3, 0, 3, -2, -2, -2, -2, 1, Y_BOTTOM, Y_BOTTOM, Y_BOTTOM, 5, 2, 4};
    foreach (ys[i]) send_point(i == 0, $urandom(), ys[i]);
  endtask

  task automatic test_long_plateaus();
    int lens[4];
    configure(1'b1, 32'sd0);
    lens = '{RUN_MAX, RUN_MAX + 1, RUN_MAX - 1, RUN_MAX + 2};
    // a long plateau at the start of the series is never labeled
    for (int i = 0; i < RUN_MAX; i++) send_point(i == 0, $urandom(), 32'sd10);
    foreach (lens[k]) begin
      send_point(1'b0, $urandom(), -32'sd1);
      repeat (lens[k]) send_point(1'b0, $urandom(), 32'sd10);
    end
    // an overlong plateau still acts as the left neighbor
    send_point(1'b0, $urandom(), 32'sd12);
    send_point(1'b0, $urandom(), -32'sd1);
  endtask

  // Random walk of plateaus around the threshold, with occasional wild levels and restarts.
  task automatic run_phase(input bit fmax, input logic signed [31:0] thr, input int budget);
    int     sent;
    int     seg_len;
    int     pick;
    longint lvl;
    bit     start;
    configure(fmax, thr);
    start = 1'b1;
    sent  = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 7) == 0) no_gaps = !no_gaps;
      pick = $urandom_range(0, 39);
      if (pick == 0) seg_len = $urandom_range(RUN_MAX - 1, RUN_MAX + 2);
      else if (pick < 12) seg_len = $urandom_range(2, 5);
      else seg_len = 1;
      if ($urandom_range(0, 11) == 0) begin
        lvl = longint'($signed($urandom()));
      end else begin
        lvl = longint'(thr) + longint'($urandom_range(0, 16)) - 8;
        if (lvl > LEVEL_TOP) lvl = LEVEL_TOP;
        if (lvl < LEVEL_BOTTOM) lvl = LEVEL_BOTTOM;
      end
      repeat (seg_len) begin
        send_point(start || $urandom_range(0, 63) == 0, $urandom(), lvl[31:0]);
        start = 1'b0;
        sent++;
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_series();
    int per_phase;
    per_phase = RANDOM_POINTS / RANDOM_PHASES;
    run_phase(1'b1, 32'sd0, per_phase);
    run_phase(1'b0, 32'sd0, per_phase);
    run_phase(1'b1, Y_TOP, per_phase);
    run_phase(1'b0, Y_BOTTOM, per_phase);
    run_phase(1'b1, Y_BOTTOM, per_phase);
    run_phase(1'b0, Y_TOP, per_phase);
    run_phase(1'($urandom_range(0, 1)), $signed($urandom()), per_phase);
  endtask

  // Output side: stall a random number of cycles after each beat.
  initial begin : peak_sink
    int stall;
    peak_bus.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      peak_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(peak_bus.valid && peak_bus.ready));
      stall = no_gaps ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        peak_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : peak_check
    peak_t want;
    if (rst_ni && peak_bus.valid && peak_bus.ready) begin
      if (peaks_due.size() == 0) begin
        report_mismatch($sformatf("unexpected peak index %0d x %0d",
                                  peak_bus.peak_index, peak_bus.peak_x));
      end else begin
        want = peaks_due.pop_front();
        if (peak_bus.peak_index !== want.index)
          report_mismatch($sformatf("peak_index got %0d want %0d",
                                    peak_bus.peak_index, want.index));
        if (peak_bus.peak_x !== want.x)
          report_mismatch($sformatf("peak_x got %0d want %0d (index %0d)",
                                    peak_bus.peak_x, want.x, want.index));
        peaks_seen++;
      end
    end
  end

  initial begin
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= REG_FIND_MAX;
    cfg_data_i            <= '0;
    point_bus.valid       <= 1'b0;
    point_bus.first_point <= 1'b0;
    point_bus.x_value     <= '0;
    point_bus.y_value     <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_unstarted_series();
    test_max_search();
    test_min_search();
    test_long_plateaus();
    test_random_series();
    wait_idle();

    $display("Ran %0d points, checked %0d of %0d predicted peaks: both modes, restarts,",
             points_sent, peaks_seen, peaks_predicted);
    $display("threshold extremes and plateaus of up to %0d points.", RUN_MAX + 2);
    if (err_count == 0) begin
      $display("plateau_peak_labeler test passed");
    end else begin
      $display("%0d mismatches", err_count);
      $display("plateau_peak_labeler test failed");
    end
    $finish;
  end

endmodule
